[hw/rtl/deadline_timer_queue_defines.svh]
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Checks that hold in the cycle after the condition, masked while in reset.
`define DTQ_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("dtq check failed");

// Checks that hold in the same cycle, masked while in reset.
`define DTQ_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("dtq check failed");

// Checks that also cover the reset cycles.
`define DTQ_ASSERT_RST(label, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("dtq reset check failed");

`endif

[hw/rtl/dtq_pkg.sv]
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int HANDLE_BITS = 8;

  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int SEQ_BITS = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths on the ports.
  localparam int HANDLE_FIELD_W   = 8;
  localparam int DEADLINE_FIELD_W = 32;
  localparam int IN_DATA_W  = ((HANDLE_FIELD_W + DEADLINE_FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_USER_W = 2;

  localparam int USER_OUTDATED = 0;
  localparam int USER_OVERFLOW = 1;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_TICK     = 1'b1
  } dtq_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_SCAN,
    ST_DECIDE
  } dtq_state_t;

  typedef struct packed {
    logic load;       // latch the input word (a tick also advances time)
    logic scan_clr;   // restart the search for the earliest due entry
    logic scan_step;  // examine one entry
    logic store;      // write the latched job into the free slot
    logic reject;     // send the latched job back with its flag
    logic take;       // remove the found entry and hold it as pending
    logic emit;       // send the pending job
    logic emit_last;  // the pending job closes the run
  } dtq_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic outdated;
    logic full;
    logic scan_last;
    logic found;
    logic pending;
    logic out_free;
  } dtq_sts_t;

endpackage

[hw/rtl/dtq_datapath.sv]
module dtq_datapath
  import dtq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast,
  input  dtq_cmd_t              cmd,
  output dtq_sts_t              sts
);

  logic [TIME_BITS-1:0]   time_r;
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [SEQ_BITS-1:0]    seq_r;

  logic [TIME_BITS-1:0]   dl_mem  [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] hnd_mem [QUEUE_DEPTH];
  logic [IDX_BITS-1:0]    ord_mem [QUEUE_DEPTH];

  logic [HANDLE_BITS-1:0] hnd_in_r;
  logic [TIME_BITS-1:0]   dl_in_r;

  logic [IDX_BITS-1:0]    scan_idx_r;
  logic                   found_r;
  logic [IDX_BITS-1:0]    best_idx_r;
  logic [TIME_BITS-1:0]   best_dl_r;
  logic [IDX_BITS-1:0]    best_ord_r;
  logic [HANDLE_BITS-1:0] best_hnd_r;

  logic                   pend_valid_r;
  logic [HANDLE_BITS-1:0] pend_hnd_r;

  logic                   out_valid_r;
  logic [HANDLE_BITS-1:0] out_hnd_r;
  logic                   out_outd_r;
  logic                   out_ovf_r;
  logic                   out_last_r;

  logic [IDX_BITS-1:0]    free_idx;
  logic                   scan_last;
  logic                   cand_due;
  logic                   cand_better;
  logic                   outdated;

  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_BITS'(i);
      end
    end
  end

  assign scan_last = (scan_idx_r == IDX_BITS'(QUEUE_DEPTH - 1));
  assign cand_due  = valid_r[scan_idx_r] && (dl_mem[scan_idx_r] <= time_r);
  // Equal deadlines fall back on insertion rank.
  assign cand_better = !found_r || (dl_mem[scan_idx_r] < best_dl_r) ||
                       ((dl_mem[scan_idx_r] == best_dl_r) &&
                        (ord_mem[scan_idx_r] < best_ord_r));
  assign outdated = (dl_in_r < time_r);

  assign sts.in_tick   = (in_tuser[0] == OP_TICK);
  assign sts.outdated  = outdated;
  assign sts.full      = &valid_r;
  assign sts.scan_last = scan_last;
  assign sts.found     = found_r;
  assign sts.pending   = pend_valid_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r       <= '0;
      valid_r      <= '0;
      seq_r        <= '0;
      scan_idx_r   <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.reject || cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load && sts.in_tick && (time_r != TIME_MAX)) begin
        time_r <= time_r + 1'b1;
      end
      if (cmd.scan_clr || cmd.take) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (!scan_last) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (cand_due && cand_better) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.store) begin
        valid_r[free_idx] <= 1'b1;
        seq_r             <= seq_r + 1'b1;
      end
      if (cmd.emit && cmd.emit_last) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.take) begin
        pend_valid_r        <= 1'b1;
        valid_r[best_idx_r] <= 1'b0;
        seq_r               <= seq_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hnd_in_r <= HANDLE_BITS'(in_tdata[0 +: HANDLE_FIELD_W]);
      dl_in_r  <= TIME_BITS'(in_tdata[HANDLE_FIELD_W +: DEADLINE_FIELD_W]);
    end
    if (cmd.scan_step && cand_due && cand_better) begin
      best_idx_r <= scan_idx_r;
      best_dl_r  <= dl_mem[scan_idx_r];
      best_ord_r <= ord_mem[scan_idx_r];
      best_hnd_r <= hnd_mem[scan_idx_r];
    end
    if (cmd.store) begin
      dl_mem[free_idx]  <= dl_in_r;
      hnd_mem[free_idx] <= hnd_in_r;
      ord_mem[free_idx] <= seq_r[IDX_BITS-1:0];
    end
    // Ranks stay dense: every survivor behind the fired job moves up by one.
    if (cmd.take) begin
      pend_hnd_r <= best_hnd_r;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (valid_r[i] && (ord_mem[i] > best_ord_r)) begin
          ord_mem[i] <= ord_mem[i] - 1'b1;
        end
      end
    end
    if (cmd.reject) begin
      out_hnd_r  <= hnd_in_r;
      out_outd_r <= outdated;
      out_ovf_r  <= !outdated;
      out_last_r <= 1'b1;
    end else if (cmd.emit) begin
      out_hnd_r  <= pend_hnd_r;
      out_outd_r <= 1'b0;
      out_ovf_r  <= 1'b0;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_hnd_r);
  assign out_tuser  = {out_ovf_r, out_outd_r};
  assign out_tlast  = out_last_r;

endmodule

[hw/rtl/dtq_ctrl.sv]
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dtq_sts_t sts,
  output dtq_cmd_t cmd
);

  dtq_state_t state_r;
  dtq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = sts.in_tick;
          state_nxt    = sts.in_tick ? ST_SCAN : ST_SCHED;
        end
      end
      ST_SCHED: begin
        if (sts.outdated || sts.full) begin
          if (sts.out_free) begin
            cmd.reject = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.store = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // A found job is held back one search so that the run's end is known
        // when the job before it goes out.
        if (sts.found) begin
          if (!sts.pending || sts.out_free) begin
            cmd.take  = 1'b1;
            cmd.emit  = sts.pending;
            state_nxt = ST_SCAN;
          end
        end else if (sts.pending) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/deadline_timer_queue.sv]
// Channel  Direction  tdata                               tuser                  tlast
// in_      input      [7:0] job_handle, [39:8] deadline   [0] operation          -
// out_     output     [7:0] fired_handle                  [0] outdated,          last
//                                                         [1] overflow
//
// A schedule word passes through a load step and a store-or-reject step. A tick word
// runs one search per fired job plus a final one: each search covers the 16 slots,
// one slot a cycle, and is followed by a decision step.
// The result register waits for out_tready without blocking the next input word;
// a stalled result only holds the controller when the next result is ready.
// Reset is synchronous and active low; all slots come out of reset empty.
module deadline_timer_queue
  import dtq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // job_handle, deadline
  input  logic [IN_USER_W-1:0]  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // fired_handle
  output logic [OUT_USER_W-1:0] out_tuser,  // outdated, overflow
  output logic                  out_tlast
);

  dtq_cmd_t cmd;
  dtq_sts_t sts;

  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[hw/rtl/dtq_checker.sv]
`include "deadline_timer_queue_defines.svh"

module dtq_checker
  import dtq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  // A rejected job is always a run of its own.
  `DTQ_ASSERT_NOW(a_flag_is_last, out_tvalid && (out_tuser[USER_OUTDATED] || out_tuser[USER_OVERFLOW]), out_tlast)

  `DTQ_ASSERT_NOW(a_one_flag, out_tvalid, !(out_tuser[USER_OUTDATED] && out_tuser[USER_OVERFLOW]))

  `DTQ_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  `DTQ_ASSERT_RST(a_reset_quiet, !rst_n, !out_tvalid)

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);

[tb/sv/tb_deadline_timer_queue.sv]
module tb_deadline_timer_queue;
  import dtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // job_handle, deadline
  logic [IN_USER_W-1:0]  in_tuser = '0;   // operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // fired_handle
  logic [OUT_USER_W-1:0] out_tuser;       // outdated, overflow
  logic                  out_tlast;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int far_budget = 3;
  int cycles = 0;

  deadline_timer_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  class timer_scoreboard;
    typedef struct {
      logic [HANDLE_FIELD_W-1:0] handle;
      bit                        outdated;
      bit                        overflow;
      bit                        last;
    } report_t;

    logic [TIME_BITS-1:0]   now;
    logic [TIME_BITS-1:0]   slot_deadline[QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] slot_handle[QUEUE_DEPTH];
    int                     slot_rank[QUEUE_DEPTH];
    bit                     slot_used[QUEUE_DEPTH];
    int                     next_rank;
    report_t                reports_due[$];
    int                     errors;

    function new();
      now = '0;
      next_rank = 0;
      errors = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
      end
    endfunction

    function void note_input(dtq_op_t op, logic [HANDLE_FIELD_W-1:0] handle,
                             logic [DEADLINE_FIELD_W-1:0] deadline);
      report_t r;
      int free_slot;
      int best;
      int live;
      int rank[QUEUE_DEPTH];
      logic [HANDLE_BITS-1:0] fired[$];
      r.outdated = 1'b0;
      r.overflow = 1'b0;
      r.last = 1'b1;
      r.handle = handle;
      if (op == OP_SCHEDULE) begin
        if (deadline < now) begin
          r.outdated = 1'b1;
          reports_due.push_back(r);
          return;
        end
        free_slot = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          r.overflow = 1'b1;
          reports_due.push_back(r);
          return;
        end
        slot_used[free_slot] = 1'b1;
        slot_deadline[free_slot] = deadline;
        slot_handle[free_slot] = handle;
        slot_rank[free_slot] = next_rank;
        next_rank++;
        return;
      end
      if (now != TIME_MAX) now++;
      // Pull due jobs out one by one: earliest deadline, then oldest insertion.
      do begin
        best = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (slot_used[i] && slot_deadline[i] <= now) begin
            if (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                (slot_deadline[i] == slot_deadline[best] && slot_rank[i] < slot_rank[best]))
              best = i;
          end
        end
        if (best >= 0) begin
          fired.push_back(slot_handle[best]);
          slot_used[best] = 1'b0;
        end
      end while (best >= 0);
      foreach (fired[k]) begin
        r.handle = fired[k];
        r.last = (k == fired.size() - 1);
        reports_due.push_back(r);
      end
      // Compact the insertion ranks of the survivors.
      live = 0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        rank[i] = 0;
        if (slot_used[i]) begin
          live++;
          for (int j = 0; j < QUEUE_DEPTH; j++)
            if (slot_used[j] && slot_rank[j] < slot_rank[i]) rank[i]++;
        end
      end
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (slot_used[i]) slot_rank[i] = rank[i];
      next_rank = live;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] handle, logic [OUT_USER_W-1:0] flags,
                               logic last);
      report_t e;
      if (reports_due.size() == 0) begin
        $error("unexpected result word: fired_handle %0h flags %b last %b", handle, flags, last);
        errors++;
        return;
      end
      e = reports_due.pop_front();
      if (handle !== e.handle) begin
        $error("fired_handle: expected %0h, actual %0h", e.handle, handle);
        errors++;
      end
      if (flags[USER_OUTDATED] !== e.outdated) begin
        $error("outdated: expected %0b, actual %0b", e.outdated, flags[USER_OUTDATED]);
        errors++;
      end
      if (flags[USER_OVERFLOW] !== e.overflow) begin
        $error("overflow: expected %0b, actual %0b", e.overflow, flags[USER_OVERFLOW]);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  timer_scoreboard sb = new();

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check each accepted word, then decide next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser, out_tlast);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Each call starts at the clock edge where the previous word was taken.
  task automatic send_word(input dtq_op_t op, input logic [HANDLE_FIELD_W-1:0] handle,
                           input logic [DEADLINE_FIELD_W-1:0] deadline);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {deadline, handle};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, handle, deadline);
  endtask

  task automatic tick();
    send_word(OP_TICK, HANDLE_FIELD_W'($urandom_range(255)), $urandom());
  endtask

  function automatic logic [DEADLINE_FIELD_W-1:0] pick_deadline();
    int r;
    logic [TIME_BITS-1:0] back;
    r = $urandom_range(99);
    if (r < 15 && sb.now != 0) begin
      back = $urandom_range(1, 20);
      if (back > sb.now) back = sb.now;
      return sb.now - back;
    end
    // A handful of far-off deadlines; they never fire and keep a slot for good.
    if (r >= 95 && far_budget > 0) begin
      far_budget--;
      return $urandom() | 32'h8000_0000;
    end
    if (r >= 85) return sb.now + $urandom_range(7, 30);
    return sb.now + $urandom_range(0, 6);
  endfunction

  // Bursts of schedules followed by a few ticks; the odd long burst can overflow the store.
  task automatic random_phase(input int items);
    int sent;
    int nsched;
    int nticks;
    sent = 0;
    while (sent < items) begin
      nsched = ($urandom_range(9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 5);
      nticks = $urandom_range(1, 4);
      repeat (nsched) begin
        send_word(OP_SCHEDULE, HANDLE_FIELD_W'($urandom_range(255)), pick_deadline());
        sent++;
      end
      repeat (nticks) begin
        tick();
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty tick, then a job that is already late.
    tick();
    send_word(OP_SCHEDULE, 8'h00, 32'h0000_0000);
    send_word(OP_SCHEDULE, 8'hFF, 32'hFFFF_FFFF);
    // Deadline equal to the current time, plus ties on two deadlines.
    send_word(OP_SCHEDULE, 8'h11, 32'd1);
    send_word(OP_SCHEDULE, 8'h33, 32'd2);
    send_word(OP_SCHEDULE, 8'h44, 32'd1);
    send_word(OP_SCHEDULE, 8'h22, 32'd2);
    tick();
    // Fill the store, then overflow it and send a late job while it is full.
    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
      send_word(OP_SCHEDULE, HANDLE_FIELD_W'(8'h80 + i), sb.now + (i % 3));
    send_word(OP_SCHEDULE, 8'hA5, sb.now + 1);
    send_word(OP_SCHEDULE, 8'h5A, 32'h0000_0000);
    // Stall the result side so the long firing run backs up into the input.
    hold_left = 500;
    repeat (3) tick();

    send_idle = 29;
    recv_idle = 87;
    random_phase(33);
    send_idle = 87;
    recv_idle = 29;
    random_phase(33);
    send_idle = 0;
    recv_idle = 0;
    random_phase(33);

    in_tvalid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.reports_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_datapath.sv
hw/rtl/dtq_ctrl.sv
hw/rtl/deadline_timer_queue.sv
hw/rtl/dtq_checker.sv
tb/sv/tb_deadline_timer_queue.sv
